### src/lazy_segment_tree_range_engine_core_defines.svh
// Assertion helpers used by the engine core.
`ifndef LAZY_SEGMENT_TREE_RANGE_ENGINE_CORE_DEFINES_SVH
`define LAZY_SEGMENT_TREE_RANGE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSTRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSTRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lstre_pkg.sv
package lstre_pkg;

  localparam int LEAVES  = 1024;
  localparam int LEAF_AW = $clog2(LEAVES);
  localparam int TAG_AW  = LEAF_AW + 1;
  localparam int PTR_W   = TAG_AW + 1;
  localparam int SIZE_W  = 11;
  localparam int VAL_W   = 48;
  localparam int OPND_W  = 32;

  localparam logic [1:0] FUNC_ASSIGN = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_ADD    = 2'd2;
  localparam logic [1:0] FUNC_REDUCE = 2'd3;

  localparam logic CFG_REDUCE_MODE = 1'b0;
  localparam logic CFG_ACTIVE_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]               func;
    logic [9:0]               index_low;
    logic [10:0]              index_end;
    logic signed [OPND_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    error;
  } out_item_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MAX
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELEM,
    ST_LEAF,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_ASSIGN,
    ST_COMBINE,
    ST_ADD_CHK,
    ST_ADD_L,
    ST_ADD_RCHK,
    ST_ADD_R,
    ST_ADD_SHIFT,
    ST_DONE
  } state_t;

endpackage

### src/lstre_ram.sv
module lstre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/lstre_alu.sv
module lstre_alu
  import lstre_pkg::*;
(
  input  alu_op_t           op,
  input  logic [VAL_W-1:0]  a,
  input  logic [VAL_W-1:0]  b,
  output logic [VAL_W-1:0]  y
);

  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      ALU_MAX: y = ($signed(a) > $signed(b)) ? a : b;
      default: y = a;
    endcase
  end

endmodule

### src/lazy_segment_tree_range_engine_core.sv
// Lazy segment tree range engine over LEAVES signed 48-bit elements. After
// reset the block runs a clearing pass that zeroes the leaf and tag
// memories; in_ready stays low meanwhile. Each item is then handled one at
// a time by a sequencer around a single shared 48-bit adder / comparator
// and two single-port-read RAMs with registered read. A point read or
// assign walks the leaf-to-root path; a range add climbs the tree level by
// level and updates each touched tag; a range reduce rebuilds each element
// in the range from its leaf and all tags on its path. An item that fails
// its range check goes straight to the done state. A result still waiting
// in the output register holds the sequencer in its last state until the
// receiver takes it. All arithmetic wraps at 48 bits.
`include "lazy_segment_tree_range_engine_core_defines.svh"

module lazy_segment_tree_range_engine_core
  import lstre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam logic [SIZE_W-1:0] LEAVES_SZ = SIZE_W'(LEAVES);
  localparam logic [PTR_W-1:0]  LEAVES_P  = PTR_W'(LEAVES);
  localparam logic [PTR_W-1:0]  ROOT_P    = PTR_W'(1);
  localparam logic [TAG_AW-1:0] CLR_LAST  = TAG_AW'(2 * LEAVES - 1);

  // configuration
  logic              reduce_mode_r;
  logic [SIZE_W-1:0] active_size_r;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [TAG_AW-1:0] clr_r, clr_nxt;
  in_item_t          req_r, req_nxt;
  logic [SIZE_W-1:0] i_r, i_nxt;
  logic [PTR_W-1:0]  p_r, p_nxt;
  logic [PTR_W-1:0]  l_r, l_nxt;
  logic [PTR_W-1:0]  r_r, r_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;
  logic              err_r, err_nxt;
  logic              first_r, first_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // memory ports
  logic              tag_we, leaf_we;
  logic [TAG_AW-1:0] tag_waddr, tag_raddr;
  logic [LEAF_AW-1:0] leaf_waddr, leaf_raddr;
  logic [VAL_W-1:0]  tag_wdata, leaf_wdata, tag_rdata, leaf_rdata;

  // shared arithmetic unit
  alu_op_t           alu_op;
  logic [VAL_W-1:0]  alu_a, alu_b, alu_y;

  logic [SIZE_W-1:0] size_eff;
  logic [VAL_W-1:0]  opnd_ext;
  logic              req_err;

  lstre_ram #(.WIDTH(VAL_W), .DEPTH(2 * LEAVES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  lstre_ram #(.WIDTH(VAL_W), .DEPTH(LEAVES)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  lstre_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Clamp the active size to the tree capacity.
  assign size_eff = (active_size_r > LEAVES_SZ) ? LEAVES_SZ : active_size_r;
  assign opnd_ext = {{(VAL_W - OPND_W){req_r.operand_value[OPND_W-1]}},
                     req_r.operand_value};

  // Range check on the incoming item: point requests need index_low in
  // bounds, ranges must be non-empty and end within the active size.
  always_comb begin
    if (in_item.func == FUNC_ASSIGN || in_item.func == FUNC_READ) begin
      req_err = ({1'b0, in_item.index_low} >= size_eff);
    end else begin
      req_err = ({1'b0, in_item.index_low} >= in_item.index_end) ||
                (in_item.index_end > size_eff);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reduce_mode_r <= 1'b0;
      active_size_r <= LEAVES_SZ;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REDUCE_MODE: reduce_mode_r <= cfg_wdata[0];
        CFG_ACTIVE_SIZE: active_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    i_r        <= i_nxt;
    p_r        <= p_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    err_r      <= err_nxt;
    first_r    <= first_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    i_nxt         = i_r;
    p_nxt         = p_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    first_nxt     = first_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;

    tag_we     = 1'b0;
    tag_waddr  = p_r[TAG_AW-1:0];
    tag_wdata  = alu_y;
    tag_raddr  = p_r[TAG_AW-1:0];
    leaf_we    = 1'b0;
    leaf_waddr = req_r.index_low[LEAF_AW-1:0];
    leaf_wdata = alu_y;
    leaf_raddr = i_r[LEAF_AW-1:0];

    alu_op = ALU_ADD;
    alu_a  = acc_r;
    alu_b  = tag_rdata;

    case (state_r)
      ST_CLEAR: begin
        // Zero one tag slot and one leaf slot per cycle.
        tag_we     = 1'b1;
        tag_waddr  = clr_r;
        tag_wdata  = '0;
        leaf_we    = 1'b1;
        leaf_waddr = clr_r[LEAF_AW-1:0];
        leaf_wdata = '0;
        clr_nxt    = clr_r + TAG_AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_item;
          i_nxt     = {1'b0, in_item.index_low};
          l_nxt     = LEAVES_P + PTR_W'(in_item.index_low);
          r_nxt     = LEAVES_P + PTR_W'(in_item.index_end);
          res_nxt   = '0;
          err_nxt   = req_err;
          first_nxt = 1'b1;
          if (req_err) begin
            state_nxt = ST_DONE;
          end else if (in_item.func == FUNC_ADD) begin
            state_nxt = ST_ADD_CHK;
          end else begin
            state_nxt = ST_ELEM;
          end
        end
      end

      // Rebuild element i: leaf base plus every tag on its path to the root.
      ST_ELEM: begin
        p_nxt   = LEAVES_P + PTR_W'(i_r);
        acc_nxt = '0;
        state_nxt = (req_r.func == FUNC_ASSIGN) ? ST_WALK_RD : ST_LEAF;
      end

      ST_LEAF: begin
        acc_nxt   = leaf_rdata;
        state_nxt = ST_WALK_RD;
      end

      ST_WALK_RD: begin
        state_nxt = ST_WALK_ACC;
      end

      ST_WALK_ACC: begin
        acc_nxt = alu_y;
        if (p_r == ROOT_P) begin
          case (req_r.func)
            FUNC_ASSIGN: state_nxt = ST_ASSIGN;
            FUNC_READ: begin
              res_nxt   = alu_y;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_COMBINE;
          endcase
        end else begin
          p_nxt     = p_r >> 1;
          state_nxt = ST_WALK_RD;
        end
      end

      // Store the base so that base plus path tags gives the operand.
      ST_ASSIGN: begin
        alu_op    = ALU_SUB;
        alu_a     = opnd_ext;
        alu_b     = acc_r;
        leaf_we   = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_COMBINE: begin
        alu_op    = reduce_mode_r ? ALU_MAX : ALU_ADD;
        alu_a     = acc_r;
        alu_b     = res_r;
        res_nxt   = first_r ? acc_r : alu_y;
        first_nxt = 1'b0;
        if ((i_r + SIZE_W'(1)) < req_r.index_end) begin
          i_nxt     = i_r + SIZE_W'(1);
          state_nxt = ST_ELEM;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // Bottom-up range add: tag the odd left bound and the odd right bound.
      ST_ADD_CHK: begin
        tag_raddr = l_r[TAG_AW-1:0];
        if (l_r >= r_r) begin
          state_nxt = ST_DONE;
        end else if (l_r[0]) begin
          state_nxt = ST_ADD_L;
        end else begin
          state_nxt = ST_ADD_RCHK;
        end
      end

      ST_ADD_L: begin
        alu_a     = tag_rdata;
        alu_b     = opnd_ext;
        tag_we    = 1'b1;
        tag_waddr = l_r[TAG_AW-1:0];
        l_nxt     = l_r + PTR_W'(1);
        state_nxt = ST_ADD_RCHK;
      end

      ST_ADD_RCHK: begin
        tag_raddr = TAG_AW'(r_r - PTR_W'(1));
        if (r_r[0]) begin
          r_nxt     = r_r - PTR_W'(1);
          state_nxt = ST_ADD_R;
        end else begin
          state_nxt = ST_ADD_SHIFT;
        end
      end

      ST_ADD_R: begin
        alu_a     = tag_rdata;
        alu_b     = opnd_ext;
        tag_we    = 1'b1;
        tag_waddr = r_r[TAG_AW-1:0];
        state_nxt = ST_ADD_SHIFT;
      end

      ST_ADD_SHIFT: begin
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = ST_ADD_CHK;
      end

      // Hold the result until the output register is free.
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.error        = err_r;
          out_item_nxt.result_value = err_r ? '0 : res_r;
          state_nxt                 = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  `LSTRE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "accepted item while busy")
  `LSTRE_ASSERT_NOW(a_error_zero, out_valid_r && out_item_r.error, out_item_r.result_value == '0, "error result not zero")
  `LSTRE_ASSERT_NOW(a_clear_blocks, state_r == ST_CLEAR, !in_ready && !out_valid_r, "item taken during clear")

endmodule
